FILE: rtl/tgs_pkg.sv
// ---------------------------------------------------------------------------
// tgs_pkg: shared types and constants of the topic Gibbs sampler
// Field widths, register codes, reset values and the command and status
// bundles that join the controller to the datapath.
// ---------------------------------------------------------------------------
package tgs_pkg;

	// default sizes of the counter tables
	localparam int TOPICS_DEF     = 16;
	localparam int VOCAB_DEF      = 16384;
	localparam int DOCS_DEF       = 4096;
	localparam int COUNT_BITS_DEF = 24;

	// request and register field widths
	localparam int TC_W    = 5;
	localparam int VS_W    = 15;
	localparam int DOC_W   = 12;
	localparam int WORD_W  = 14;
	localparam int TOPIC_W = 4;
	localparam int RND_W   = 16;
	localparam int REG_W   = 1;

	// configuration register indexes
	localparam logic [REG_W-1:0] REG_TOPIC_COUNT = 1'b0;
	localparam logic [REG_W-1:0] REG_VOCAB_SIZE  = 1'b1;

	// configuration reset values
	localparam logic [TC_W-1:0] TOPIC_COUNT_RST = 5'd2;
	localparam logic [VS_W-1:0] VOCAB_SIZE_RST  = 15'd16384;

	// commands from the controller
	typedef struct packed {
		logic clr;       // write one clearing row
		logic cap;       // capture a request
		logic idx1;      // index wrap, reciprocal product
		logic idx2;      // index wrap, correction
		logic rd;        // read the counter rows
		logic k_init;    // start the weight loop
		logic div_load;  // load the divider for topic k
		logic div_step;  // four quotient bits
		logic mul_lo;    // low partial product
		logic mul_hi;    // high partial product
		logic acc;       // store weight, add to sum, advance k
		logic thr1;      // threshold partial products
		logic thr2;      // threshold sum, start the scan
		logic scan;      // one step of the cumulative scan
		logic wr;        // write back the counters
		logic out_load;  // load the result register
	} cmd_t;

	// status back to the controller
	typedef struct packed {
		logic clr_last;
		logic resample;
		logic div_last;
		logic k_last;
		logic hit;
	} sts_t;

endpackage

FILE: rtl/tgs_ctrl.sv
// ---------------------------------------------------------------------------
// tgs_ctrl: sequencer of the topic Gibbs sampler
// Runs the clearing pass, then steps each request through index wrap, table
// read and the write-back; a resample also runs the per-topic weight loop and the scan.
// ---------------------------------------------------------------------------
module tgs_ctrl
	import tgs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd,
	input  sts_t sts
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_IDX1  = 4'd2;
	localparam logic [3:0] S_IDX2  = 4'd3;
	localparam logic [3:0] S_READ  = 4'd4;
	localparam logic [3:0] S_LOAD  = 4'd5;
	localparam logic [3:0] S_DLOAD = 4'd6;
	localparam logic [3:0] S_DRUN  = 4'd7;
	localparam logic [3:0] S_MLO   = 4'd8;
	localparam logic [3:0] S_MHI   = 4'd9;
	localparam logic [3:0] S_ACC   = 4'd10;
	localparam logic [3:0] S_THR1  = 4'd11;
	localparam logic [3:0] S_THR2  = 4'd12;
	localparam logic [3:0] S_SCAN  = 4'd13;
	localparam logic [3:0] S_WRITE = 4'd14;
	localparam logic [3:0] S_DONE  = 4'd15;

	logic [3:0] state_q, state_d;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign s_tready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.cap = 1'b1;
					state_d = S_IDX1;
				end
			end
			S_IDX1: begin
				cmd.idx1 = 1'b1;
				state_d  = S_IDX2;
			end
			S_IDX2: begin
				cmd.idx2 = 1'b1;
				state_d  = S_READ;
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (sts.resample) begin
					cmd.k_init = 1'b1;
					state_d    = S_DLOAD;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_DLOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DRUN;
			end
			S_DRUN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_MLO;
			end
			S_MLO: begin
				cmd.mul_lo = 1'b1;
				state_d    = S_MHI;
			end
			S_MHI: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.k_last ? S_THR1 : S_DLOAD;
			end
			S_THR1: begin
				cmd.thr1 = 1'b1;
				state_d  = S_THR2;
			end
			S_THR2: begin
				cmd.thr2 = 1'b1;
				state_d  = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.k_last) state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.wr  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// result valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !s_tready)
		else $error("request taken during clearing pass");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_IDX1))
		else $error("accepted request did not start");

	a_done_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (m_tvalid && state_q == S_IDLE))
		else $error("finished request did not reach the result register");
`endif

endmodule

FILE: rtl/tgs_datapath.sv
// ---------------------------------------------------------------------------
// tgs_datapath: counter tables and arithmetic of the topic Gibbs sampler
// Holds the word-topic and document-topic rows, document lengths, topic
// totals, a radix-16 divider, a shared multiplier and the scan logic.
// ---------------------------------------------------------------------------
module tgs_datapath
	import tgs_pkg::*;
#(
	parameter int TOPICS     = TOPICS_DEF,
	parameter int VOCAB      = VOCAB_DEF,
	parameter int DOCS       = DOCS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_we,
	input  logic [REG_W-1:0]   cfg_index,
	input  logic [VS_W-1:0]    cfg_data,
	input  logic               operation,
	input  logic [DOC_W-1:0]   doc_index,
	input  logic [WORD_W-1:0]  word_index,
	input  logic [TOPIC_W-1:0] current_topic,
	input  logic [RND_W-1:0]   random_fraction,
	output logic [TOPIC_W-1:0] new_topic
);

	localparam int TUSE  = (TOPICS < 16) ? TOPICS : 16;
	localparam int WIW   = $clog2(TUSE);
	localparam int TKW   = $clog2(TOPICS);
	localparam int DAW   = $clog2(DOCS);
	localparam int VAW   = $clog2(VOCAB);
	localparam int CLR   = (VOCAB > DOCS) ? VOCAB : DOCS;
	localparam int CLW   = $clog2(CLR);
	localparam int NW    = COUNT_BITS + 33;
	localparam int NP    = ((NW + 3) / 4) * 4;
	localparam int ITER  = NP / 4;
	localparam int ITW   = (ITER > 1) ? $clog2(ITER) : 1;
	localparam int DW    = ((COUNT_BITS > VS_W) ? COUNT_BITS : VS_W) + 1;
	localparam int MW    = COUNT_BITS + 1;
	localparam int QHW   = NP - 32;
	localparam int QAW   = (QHW > 32) ? QHW : 32;
	localparam int PW    = QAW + MW;
	localparam int FW    = PW + 33;
	localparam logic [32:0] DOC_RECIP  = 33'(((64'd1 << 32) + 64'(DOCS) - 64'd1) / 64'(DOCS));
	localparam logic [32:0] WORD_RECIP = 33'(((64'd1 << 32) + 64'(VOCAB) - 64'd1) / 64'(VOCAB));

	function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] c);
		return (&c) ? c : COUNT_BITS'(c + 1'b1);
	endfunction

	function automatic logic [COUNT_BITS-1:0] cnt_dec(input logic [COUNT_BITS-1:0] c);
		return (c == '0) ? c : COUNT_BITS'(c - 1'b1);
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	// configuration
	logic [TC_W-1:0] topic_count_q;
	logic [VS_W-1:0] vocab_size_q;
	logic [TC_W-1:0] kn;
	logic [VS_W-1:0] vs_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topic_count_q <= TOPIC_COUNT_RST;
			vocab_size_q  <= VOCAB_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOPIC_COUNT: topic_count_q <= cfg_data[TC_W-1:0];
				REG_VOCAB_SIZE:  vocab_size_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// topics in use and smoothing term
	always_comb begin
		if (topic_count_q == '0) begin
			kn = TC_W'(1);
		end else if (topic_count_q > TC_W'(TUSE)) begin
			kn = TC_W'(TUSE);
		end else begin
			kn = topic_count_q;
		end
		vs_eff = (vocab_size_q == '0) ? VS_W'(1) : vocab_size_q;
	end

	// request registers
	logic                 op_q;
	logic [DOC_W-1:0]     doc_raw_q;
	logic [WORD_W-1:0]    word_raw_q;
	logic [TOPIC_W-1:0]   cur_q;
	logic [RND_W-1:0]     rnd_q;
	logic [TOPIC_W-1:0]   nt_q;
	logic [TOPIC_W-1:0]   out_q;
	logic [TOPIC_W-1:0]   cur_in;

	always_comb begin
		if ({1'b0, current_topic} >= kn) begin
			cur_in = TOPIC_W'(kn - 1'b1);
		end else begin
			cur_in = current_topic;
		end
	end

	// index wrap by reciprocal product with one correction
	logic [14:0]    dq_q, wq_q;
	logic [DAW-1:0] doc_q;
	logic [VAW-1:0] wrd_q;
	logic [46:0]    dprod, wprod;
	logic [39:0]    dback, wback, drem, wrem;

	always_comb begin
		dprod = 47'(doc_raw_q) * 47'(DOC_RECIP);
		wprod = 47'(word_raw_q) * 47'(WORD_RECIP);
		dback = 40'(dq_q) * 40'(DOCS);
		wback = 40'(wq_q) * 40'(VOCAB);
		if (dback > 40'(doc_raw_q)) begin
			drem = 40'(doc_raw_q) + 40'(DOCS) - dback;
		end else begin
			drem = 40'(doc_raw_q) - dback;
		end
		if (wback > 40'(word_raw_q)) begin
			wrem = 40'(word_raw_q) + 40'(VOCAB) - wback;
		end else begin
			wrem = 40'(word_raw_q) - wback;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q       <= operation;
			doc_raw_q  <= doc_index;
			word_raw_q <= word_index;
			cur_q      <= cur_in;
			rnd_q      <= random_fraction;
		end
		if (cmd.idx1) begin
			dq_q <= dprod[46:32];
			wq_q <= wprod[46:32];
		end
		if (cmd.idx2) begin
			doc_q <= DAW'(drem);
			wrd_q <= VAW'(wrem);
		end
		if (cmd.out_load) begin
			out_q <= nt_q;
		end
	end

	assign new_topic = out_q;

	// clearing pass counter
	logic [CLW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= CLW'(clr_q + 1'b1);
		end
	end

	// counter tables
	logic [TOPICS-1:0][COUNT_BITS-1:0] wt_mem [VOCAB];
	logic [TOPICS-1:0][COUNT_BITS-1:0] dt_mem [DOCS];
	logic [COUNT_BITS-1:0]             len_mem [DOCS];
	logic [TOPICS-1:0][COUNT_BITS-1:0] wt_row_q, dt_row_q, wt_new, dt_new;
	logic [COUNT_BITS-1:0]             len_q;
	logic [COUNT_BITS-1:0]             tot_q [TOPICS];
	logic [TKW-1:0]                    cur_l, nt_l, k_l;
	logic                              same_topic;
	logic                              move;
	logic                              wt_we, dt_we;
	logic [VAW-1:0]                    wt_wa;
	logic [DAW-1:0]                    dt_wa;

	assign cur_l      = TKW'(cur_q);
	assign nt_l       = TKW'(nt_q);
	assign same_topic = (nt_q == cur_q);
	assign move       = cmd.wr && op_q && !same_topic;

	// new row contents: count under the topic, or move between topics
	always_comb begin
		wt_new = wt_row_q;
		dt_new = dt_row_q;
		if (op_q) begin
			wt_new[cur_l] = cnt_dec(wt_row_q[cur_l]);
			dt_new[cur_l] = cnt_dec(dt_row_q[cur_l]);
			wt_new[nt_l]  = cnt_inc(wt_row_q[nt_l]);
			dt_new[nt_l]  = cnt_inc(dt_row_q[nt_l]);
		end else begin
			wt_new[cur_l] = cnt_inc(wt_row_q[cur_l]);
			dt_new[cur_l] = cnt_inc(dt_row_q[cur_l]);
		end
	end

	always_comb begin
		wt_we = (cmd.clr && ({1'b0, clr_q} < (CLW + 1)'(VOCAB))) || (cmd.wr && !op_q) || move;
		dt_we = (cmd.clr && ({1'b0, clr_q} < (CLW + 1)'(DOCS))) || (cmd.wr && !op_q) || move;
		wt_wa = cmd.clr ? VAW'(clr_q) : wrd_q;
		dt_wa = cmd.clr ? DAW'(clr_q) : doc_q;
	end

	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[wt_wa] <= cmd.clr ? '0 : wt_new;
		end
		if (cmd.rd) begin
			wt_row_q <= wt_mem[wrd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (dt_we) begin
			dt_mem[dt_wa] <= cmd.clr ? '0 : dt_new;
		end
		if (cmd.rd) begin
			dt_row_q <= dt_mem[doc_q];
		end
	end

	always_ff @(posedge clk) begin
		if (dt_we && (cmd.clr || !op_q)) begin
			len_mem[dt_wa] <= cmd.clr ? '0 : cnt_inc(len_q);
		end
		if (cmd.rd) begin
			len_q <= len_mem[doc_q];
		end
	end

	// topic totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOPICS; i++) begin
				tot_q[i] <= '0;
			end
		end else if (cmd.wr && !op_q) begin
			tot_q[cur_l] <= cnt_inc(tot_q[cur_l]);
		end else if (move) begin
			tot_q[cur_l] <= cnt_dec(tot_q[cur_l]);
			tot_q[nt_l]  <= cnt_inc(tot_q[nt_l]);
		end
	end

	// topic loop index
	logic [TC_W-1:0] k_q;
	logic            k_is_cur;

	assign k_l      = TKW'(k_q);
	assign k_is_cur = (k_q == {1'b0, cur_q});

	// divider: floor(((f+1) << 32) / (total + vocab)), four bits a cycle
	logic [DW-1:0]         div_rem_q, div_dvs_q;
	logic [NP-1:0]         div_num_q;
	logic [ITW-1:0]        div_cnt_q;
	logic [MW-1:0]         m_q;
	logic [COUNT_BITS-1:0] f_adj, s_adj;
	logic [DW:0]           dv_t;
	logic [DW-1:0]         dv_r;
	logic [NP-1:0]         dv_n;

	always_comb begin
		f_adj = wt_row_q[k_l];
		s_adj = dt_row_q[k_l];
		if (k_is_cur && f_adj != '0) f_adj = COUNT_BITS'(f_adj - 1'b1);
		if (k_is_cur && s_adj != '0) s_adj = COUNT_BITS'(s_adj - 1'b1);
	end

	always_comb begin
		dv_r = div_rem_q;
		dv_n = div_num_q;
		dv_t = '0;
		for (int i = 0; i < 4; i++) begin
			dv_t = {dv_r, dv_n[NP-1]};
			dv_n = {dv_n[NP-2:0], 1'b0};
			if (dv_t >= {1'b0, div_dvs_q}) begin
				dv_t    = dv_t - {1'b0, div_dvs_q};
				dv_n[0] = 1'b1;
			end
			dv_r = dv_t[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			div_rem_q <= '0;
			div_num_q <= NP'({MW'(f_adj) + MW'(1), 32'd0});
			div_dvs_q <= DW'(tot_q[k_l]) + DW'(vs_eff);
			m_q       <= MW'(s_adj) + MW'(1);
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_rem_q <= dv_r;
			div_num_q <= dv_n;
			div_cnt_q <= ITW'(div_cnt_q + 1'b1);
		end
	end

	// shared multiplier for the two halves of the quotient
	logic [QAW-1:0] mul_a;
	logic [PW-1:0]  mul_p, p_lo_q, p_hi_q;
	logic [FW-1:0]  full;
	logic [63:0]    weight;

	always_comb begin
		mul_a  = cmd.mul_hi ? QAW'(div_num_q[NP-1:32]) : QAW'(div_num_q[31:0]);
		mul_p  = PW'(mul_a) * PW'(m_q);
		full   = (FW'(p_hi_q) << 32) + FW'(p_lo_q);
		weight = (|full[FW-1:64]) ? {64{1'b1}} : full[63:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_lo) p_lo_q <= mul_p;
		if (cmd.mul_hi) p_hi_q <= mul_p;
	end

	// weights, sum, threshold and scan
	logic [63:0] w_q [TUSE];
	logic [63:0] sum_q, cum_q, thr_q, thr_hi_q;
	logic [15:0] thr_lo_q;
	logic [63:0] cum_n;
	logic [31:0] thr_lo_p;
	logic        hit;

	always_comb begin
		cum_n    = sat_add(cum_q, w_q[WIW'(k_q)]);
		hit      = cum_n > thr_q;
		thr_lo_p = 32'(sum_q[15:0]) * 32'(rnd_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			nt_q <= cur_in;
		end else if (cmd.thr2) begin
			nt_q <= '0;
		end else if (cmd.scan && hit) begin
			nt_q <= TOPIC_W'(k_q);
		end
		if (cmd.k_init || cmd.thr2) begin
			k_q <= '0;
		end else if (cmd.acc || cmd.scan) begin
			k_q <= TC_W'(k_q + 1'b1);
		end
		if (cmd.k_init) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sat_add(sum_q, weight);
		end
		if (cmd.acc) begin
			w_q[WIW'(k_q)] <= weight;
		end
		if (cmd.thr1) begin
			thr_hi_q <= 64'(sum_q[63:16]) * 64'(rnd_q);
			thr_lo_q <= thr_lo_p[31:16];
		end
		if (cmd.thr2) begin
			thr_q <= thr_hi_q + 64'(thr_lo_q);
			cum_q <= '0;
		end else if (cmd.scan) begin
			cum_q <= cum_n;
		end
	end

	// status
	always_comb begin
		sts.clr_last = (clr_q == CLW'(CLR - 1));
		sts.resample = op_q;
		sts.div_last = (div_cnt_q == ITW'(ITER - 1));
		sts.k_last   = (k_q == TC_W'(kn - 1'b1));
		sts.hit      = hit;
	end

endmodule

FILE: rtl/topic_gibbs_sampler_top.sv
// An add request goes straight from the table read to the write-back; a resample
// runs the divider and multiplier once per topic in use, then a scan that stops at
// the first hit or at the last topic in use.
// One request is in work at a time; the divider loop over topics sets the rate.
// Reset clears all counter tables in a clearing pass that runs before the first
// request is taken.
// ---------------------------------------------------------------------------
// topic_gibbs_sampler_top: collapsed Gibbs sampler step for topic models
// Joins the sequencer and the datapath and unpacks the stream payloads.
// ---------------------------------------------------------------------------
module topic_gibbs_sampler_top
	import tgs_pkg::*;
#(
	parameter int TOPICS     = TOPICS_DEF,
	parameter int VOCAB      = VOCAB_DEF,
	parameter int DOCS       = DOCS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// doc_index[11:0], word_index[25:12], current_topic[29:26],
	// random_fraction[45:30], zero fill [47:46]
	input  logic [47:0]      s_tdata,
	// operation[0]
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// new_topic[3:0], zero fill [7:4]
	output logic [7:0]       m_tdata,
	input  logic             cfg_we,
	input  logic [REG_W-1:0] cfg_index,
	input  logic [VS_W-1:0]  cfg_data
);

	cmd_t               cmd;
	sts_t               sts;
	logic [TOPIC_W-1:0] new_topic;

	tgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	tgs_datapath #(
		.TOPICS     (TOPICS),
		.VOCAB      (VOCAB),
		.DOCS       (DOCS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.operation       (s_tuser),
		.doc_index       (s_tdata[11:0]),
		.word_index      (s_tdata[25:12]),
		.current_topic   (s_tdata[29:26]),
		.random_fraction (s_tdata[45:30]),
		.new_topic       (new_topic)
	);

	assign m_tdata = {4'd0, new_topic};

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: topic Gibbs sampler testbench
// Drives add and resample requests into the sampler, predicts each new topic
// from a local copy of the counter tables and checks every result in order.
// ---------------------------------------------------------------------------
module tb_top;
	import tgs_pkg::*;

	localparam int NTOP = 16;
	localparam int NVOC = 16384;
	localparam int NDOC = 4096;
	localparam logic [23:0] CNT_MAX = 24'hFFFFFF;
	localparam logic [63:0] SAT = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam bit OP_ADD = 1'b0;
	localparam bit OP_RESAMPLE = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [REG_W-1:0] cfg_index = REG_TOPIC_COUNT;
	logic [VS_W-1:0] cfg_data = '0;

	// sparse model tables, default zero
	logic [23:0] word_topic [int];
	logic [23:0] doc_topic [int];
	logic [23:0] doc_len [int];
	logic [23:0] topic_tot [NTOP];
	logic [TC_W-1:0] topic_cnt_reg;
	logic [VS_W-1:0] vocab_reg;

	logic [3:0] topic_queue [$];
	int errors = 0;
	int n_results = 0;
	int n_resample = 0;
	bit calm = 1'b0;

	topic_gibbs_sampler_top DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#400ms;
		$display("timeout at %0t", $time);
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [23:0] rd_tab(ref logic [23:0] t [int], input int k);
		return t.exists(k) ? t[k] : 24'd0;
	endfunction

	function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
		return (a > SAT - b) ? SAT : a + b;
	endfunction

	function automatic logic [63:0] smul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = a * b;
		return (p[127:64] != 0) ? SAT : p[63:0];
	endfunction

	function automatic logic [63:0] weight_quot(logic [63:0] n, logic [63:0] d);
		logic [127:0] q;
		q = ({64'd0, n} << 32) / d;
		return (q[127:64] != 0) ? SAT : q[63:0];
	endfunction

	function automatic void bump(ref logic [23:0] t [int], input int k, input bit up);
		logic [23:0] v;
		v = rd_tab(t, k);
		if (up && v != CNT_MAX) v++;
		else if (!up && v != 0) v--;
		t[k] = v;
	endfunction

	// predict the new topic and update the model tables
	function automatic logic [3:0] sample_topic(bit op, logic [11:0] doc, logic [13:0] wrd,
			logic [3:0] cur_in, logic [15:0] rnd);
		int kn, cur, nt;
		logic [63:0] w [16];
		logic [63:0] sum, thr, cum, f, s, vs;
		kn = topic_cnt_reg;
		if (kn < 1) kn = 1;
		if (kn > 16) kn = 16;
		cur = (cur_in >= kn) ? kn - 1 : cur_in;
		nt = cur;
		if (op == OP_ADD) begin
			bump(word_topic, cur * NVOC + wrd, 1);
			bump(doc_topic, cur * NDOC + doc, 1);
			bump(doc_len, doc, 1);
			if (topic_tot[cur] != CNT_MAX) topic_tot[cur]++;
		end else begin
			vs = (vocab_reg == 0) ? 1 : vocab_reg;
			sum = 0;
			cum = 0;
			nt = 0;
			for (int k = 0; k < kn; k++) begin
				f = rd_tab(word_topic, k * NVOC + wrd);
				s = rd_tab(doc_topic, k * NDOC + doc);
				if (k == cur && f > 0) f--;
				if (k == cur && s > 0) s--;
				w[k] = smul(weight_quot(f + 1, topic_tot[k] + vs), s + 1);
				sum = sadd(sum, w[k]);
			end
			thr = (sum >> 16) * rnd + (((sum & 64'hFFFF) * rnd) >> 16);
			for (int k = 0; k < kn; k++) begin
				cum = sadd(cum, w[k]);
				if (cum > thr) begin
					nt = k;
					break;
				end
			end
			if (nt != cur) begin
				bump(word_topic, cur * NVOC + wrd, 0);
				bump(word_topic, nt * NVOC + wrd, 1);
				bump(doc_topic, cur * NDOC + doc, 0);
				bump(doc_topic, nt * NDOC + doc, 1);
				if (topic_tot[cur] != 0) topic_tot[cur]--;
				if (topic_tot[nt] != CNT_MAX) topic_tot[nt]++;
			end
		end
		return nt[3:0];
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 32);
	endfunction

	// send one token request
	task automatic send_token(bit op, logic [11:0] doc, logic [13:0] wrd,
			logic [3:0] cur, logic [15:0] rnd);
		@(negedge clk);
		while (idle_now()) @(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, rnd, cur, wrd, doc};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		topic_queue.insert(topic_queue.size(), sample_topic(op, doc, wrd, cur, rnd));
		if (op == OP_RESAMPLE) n_resample++;
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// drain, then write one register
	task automatic write_reg(logic [REG_W-1:0] idx, logic [VS_W-1:0] val);
		while (topic_queue.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TOPIC_COUNT) topic_cnt_reg = val[TC_W-1:0];
		else vocab_reg = val;
	endtask

	// randomize result backpressure
	always @(negedge clk) begin
		if (arst_n) m_tready <= !idle_now();
	end

	// check each result against the oldest prediction
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			n_results++;
			if (topic_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual new_topic %0d", $time, m_tdata[3:0]);
			end else begin
				logic [3:0] want;
				want = topic_queue.pop_front();
				if (m_tdata[3:0] !== want) begin
					errors++;
					$display("%0t: new_topic expected %0d actual %0d",
						$time, want, m_tdata[3:0]);
				end
			end
		end
	end

	task automatic test_directed();
		send_token(OP_RESAMPLE, 12'd0, 14'd0, 4'd0, 16'd0);
		send_token(OP_ADD, 12'hFFF, 14'h3FFF, 4'd15, 16'hFFFF);
		send_token(OP_ADD, 12'd0, 14'd0, 4'd0, 16'd0);
		send_token(OP_RESAMPLE, 12'hFFF, 14'h3FFF, 4'd1, 16'hFFFF);
		send_token(OP_RESAMPLE, 12'd0, 14'd0, 4'd0, 16'h8000);
		write_reg(REG_TOPIC_COUNT, 15'd0);
		send_token(OP_ADD, 12'd5, 14'd5, 4'd9, 16'd1);
		send_token(OP_RESAMPLE, 12'd5, 14'd5, 4'd3, 16'hFFFF);
		write_reg(REG_TOPIC_COUNT, 15'd31);
		write_reg(REG_VOCAB_SIZE, 15'd0);
		send_token(OP_ADD, 12'd7, 14'd7, 4'd15, 16'd0);
		send_token(OP_RESAMPLE, 12'd7, 14'd7, 4'd15, 16'hFFFF);
		send_token(OP_RESAMPLE, 12'd7, 14'd7, 4'd0, 16'd0);
		write_reg(REG_VOCAB_SIZE, 15'h7FFF);
		send_token(OP_RESAMPLE, 12'd7, 14'd7, 4'd2, 16'h1234);
		write_reg(REG_TOPIC_COUNT, 15'd16);
		write_reg(REG_VOCAB_SIZE, 15'd1);
		send_token(OP_RESAMPLE, 12'hAAA, 14'h1555, 4'd10, 16'h5555);
	endtask

	// tokens from a small corpus, so counts build up
	task automatic test_random(int n, int tc, int vs);
		write_reg(REG_TOPIC_COUNT, tc[VS_W-1:0]);
		write_reg(REG_VOCAB_SIZE, vs[VS_W-1:0]);
		for (int i = 0; i < n; i++) begin
			bit op;
			logic [11:0] doc;
			logic [13:0] wrd;
			op = ($urandom_range(99) < 35) ? OP_ADD : OP_RESAMPLE;
			doc = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(7));
			wrd = ($urandom_range(9) == 0) ? 14'($urandom)
				: (14'($urandom_range(15)) | 14'h2A00);
			send_token(op, doc, wrd, 4'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		topic_cnt_reg = TOPIC_COUNT_RST;
		vocab_reg = VOCAB_SIZE_RST;
		foreach (topic_tot[k]) topic_tot[k] = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(300, 2, 16384);
		test_random(300, 16, 3);
		calm = 1'b1;
		test_random(250, 8, 1);
		calm = 1'b0;
		test_random(350, 5, 200);
		test_random(350, 1, 16384);
		while (topic_queue.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		$display("Sent adds and resamples over topic counts 0 to 31 and vocab sizes 0 to 32767.");
		$display("Checked %0d results, %0d of them resamples.", n_results, n_resample);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
